// ----- hw/rtl/mld_pkg.sv -----
// Shared types and constants of the magic/length packet deframer.
`default_nettype none

package mld_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned AddrWidth   = 5;
    localparam int unsigned LengthWidth = 16;
    localparam int unsigned CountWidth  = 15;
    localparam int unsigned IndexWidth  = 3;
    localparam int unsigned KindWidth   = 2;
    localparam int unsigned QueueDepth  = 2;

    localparam logic [2:0] REG_MAGIC_WORD  = 3'd0;
    localparam logic [2:0] REG_NAME_ZERO   = 3'd1;
    localparam logic [2:0] REG_NAME_ONE    = 3'd2;
    localparam logic [2:0] REG_NAME_TWO    = 3'd3;
    localparam logic [2:0] REG_NAME_THREE  = 3'd4;
    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd5;

    localparam logic [31:0]           MagicReset      = 32'h4655_5A5A;
    localparam logic [31:0]           NameZeroReset   = 32'h4543_484F;
    localparam logic [31:0]           NameOneReset    = 32'h5049_5045;
    localparam logic [31:0]           NameTwoReset    = 32'h4558_4543;
    localparam logic [31:0]           NameThreeReset  = 32'h5052_4F43;
    localparam logic [CountWidth-1:0] MaxPayloadReset = 15'd9990;

    localparam logic [KindWidth-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KindWidth-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KindWidth-1:0] KIND_DROP    = 2'd2;

    localparam logic [IndexWidth-1:0] RECEIVER_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [31:0]           magic_word;
        logic [31:0]           name_zero;
        logic [31:0]           name_one;
        logic [31:0]           name_two;
        logic [31:0]           name_three;
        logic [CountWidth-1:0] max_payload;
    } mld_cfg_t;

    typedef struct packed {
        logic [KindWidth-1:0]   kind;
        logic [IndexWidth-1:0]  receiver_index;
        logic [7:0]             payload_byte;
        logic [CountWidth-1:0]  byte_index;
        logic [LengthWidth-1:0] packet_length;
        logic                   last;
    } mld_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mld_cfg.sv -----
// APB configuration registers of the deframer.
`default_nettype none

module mld_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mld_pkg::AddrWidth-1:0] paddr,
    input  wire logic [mld_pkg::DataWidth-1:0] pwdata,
    output logic      [mld_pkg::DataWidth-1:0] prdata,
    output logic                               pready,
    output mld_pkg::mld_cfg_t                  cfg
);
    import mld_pkg::*;

    mld_cfg_t   cfg_reg;
    logic [2:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[AddrWidth-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word  <= MagicReset;
            cfg_reg.name_zero   <= NameZeroReset;
            cfg_reg.name_one    <= NameOneReset;
            cfg_reg.name_two    <= NameTwoReset;
            cfg_reg.name_three  <= NameThreeReset;
            cfg_reg.max_payload <= MaxPayloadReset;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MAGIC_WORD:  cfg_reg.magic_word  <= pwdata;
                REG_NAME_ZERO:   cfg_reg.name_zero   <= pwdata;
                REG_NAME_ONE:    cfg_reg.name_one    <= pwdata;
                REG_NAME_TWO:    cfg_reg.name_two    <= pwdata;
                REG_NAME_THREE:  cfg_reg.name_three  <= pwdata;
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= pwdata[CountWidth-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAGIC_WORD:  prdata = cfg_reg.magic_word;
            REG_NAME_ZERO:   prdata = cfg_reg.name_zero;
            REG_NAME_ONE:    prdata = cfg_reg.name_one;
            REG_NAME_TWO:    prdata = cfg_reg.name_two;
            REG_NAME_THREE:  prdata = cfg_reg.name_three;
            REG_MAX_PAYLOAD: prdata = {{(DataWidth-CountWidth){1'b0}}, cfg_reg.max_payload};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mld_front.sv -----
// Front end: hunts for the magic word, takes the header and classifies each byte.
`default_nettype none

module mld_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mld_pkg::mld_cfg_t    cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           stream_byte,
    input  wire logic                 queue_ready,
    output logic                      push_valid,
    output mld_pkg::mld_result_t      push_data
);
    import mld_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t                  phase_reg,   phase_next;
    logic [31:0]             window_reg,  window_next;
    logic [2:0]              count_reg,   count_next;
    logic [31:0]             name_reg,    name_next;
    logic [LengthWidth-1:0]  length_reg,  length_next;
    logic [CountWidth-1:0]   pcount_reg,  pcount_next;
    logic [IndexWidth-1:0]   match_reg,   match_next;

    logic                    accept;
    logic                    emit;
    logic [KindWidth-1:0]    emit_kind;
    logic [7:0]              emit_byte;
    logic [CountWidth-1:0]   emit_index;
    logic                    emit_last;
    logic [31:0]             shifted_window;
    logic [LengthWidth-1:0]  full_length;
    logic [LengthWidth-1:0]  pcount_inc;
    logic                    fin;

    function automatic logic [IndexWidth-1:0] classify(input logic [31:0] nm,
                                                       input mld_cfg_t c);
        logic [IndexWidth-1:0] idx;
        if (nm == c.name_zero)
            idx = 3'd0;
        else if (nm == c.name_one)
            idx = 3'd1;
        else if (nm == c.name_two)
            idx = 3'd2;
        else if (nm == c.name_three)
            idx = 3'd3;
        else
            idx = RECEIVER_UNKNOWN;
        return idx;
    endfunction

    assign in_ready       = queue_ready;
    assign accept         = in_valid && in_ready;
    assign shifted_window = {window_reg[23:0], stream_byte};
    assign full_length    = {stream_byte, length_reg[7:0]};
    assign pcount_inc     = {1'b0, pcount_reg} + 16'd1;
    assign fin            = pcount_inc >= length_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        name_next   = name_reg;
        length_next = length_reg;
        pcount_next = pcount_reg;
        match_next  = match_reg;
        emit        = 1'b0;
        emit_kind   = KIND_PAYLOAD;
        emit_byte   = 8'd0;
        emit_index  = '0;
        emit_last   = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (count_reg < 3'd4)
                begin
                    name_next  = {name_reg[23:0], stream_byte};
                    count_next = count_reg + 3'd1;
                end
                else if (count_reg == 3'd4)
                begin
                    length_next = {8'd0, stream_byte};
                    count_next  = 3'd5;
                end
                else
                begin
                    length_next = full_length;
                    match_next  = classify(name_reg, cfg);
                    pcount_next = '0;
                    if (full_length == '0)
                    begin
                        emit        = 1'b1;
                        emit_kind   = KIND_EMPTY;
                        emit_last   = 1'b1;
                        phase_next  = PH_HUNT;
                        window_next = '0;
                        count_next  = '0;
                    end
                    else if (full_length > {1'b0, cfg.max_payload})
                    begin
                        emit        = 1'b1;
                        emit_kind   = KIND_DROP;
                        emit_last   = 1'b1;
                        phase_next  = PH_HUNT;
                        window_next = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit        = 1'b1;
                emit_kind   = KIND_PAYLOAD;
                emit_byte   = stream_byte;
                emit_index  = pcount_reg;
                emit_last   = fin;
                pcount_next = pcount_inc[CountWidth-1:0];
                if (fin)
                begin
                    phase_next  = PH_HUNT;
                    window_next = '0;
                    count_next  = '0;
                end
            end
            default:
            begin
                phase_next  = PH_HUNT;
                window_next = shifted_window;
                if (count_reg < 3'd4)
                    count_next = count_reg + 3'd1;
                if ((count_next >= 3'd4) && (shifted_window == cfg.magic_word))
                begin
                    phase_next  = PH_HEADER;
                    count_next  = '0;
                    window_next = '0;
                    name_next   = '0;
                    length_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            count_reg  <= '0;
            name_reg   <= '0;
            length_reg <= '0;
            pcount_reg <= '0;
            match_reg  <= RECEIVER_UNKNOWN;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            name_reg   <= name_next;
            length_reg <= length_next;
            pcount_reg <= pcount_next;
            match_reg  <= match_next;
        end
    end

    assign push_valid                = accept && emit;
    assign push_data.kind            = emit_kind;
    assign push_data.receiver_index  = match_next;
    assign push_data.payload_byte    = emit_byte;
    assign push_data.byte_index      = emit_index;
    assign push_data.packet_length   = length_next;
    assign push_data.last            = emit_last;

endmodule

`default_nettype wire

// ----- hw/rtl/mld_queue.sv -----
// Result queue between the front end and the output channel.
`default_nettype none

module mld_queue #(
    parameter int unsigned DEPTH = mld_pkg::QueueDepth
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    input  wire mld_pkg::mld_result_t push_data,
    output logic                      push_ready,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output mld_pkg::mld_result_t      pop_data
);
    import mld_pkg::*;

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

    mld_result_t           slot_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [CntWidth-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != FullCount;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/magic_length_packet_deframer.sv -----
// Top level of the magic/length packet deframer.
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_ready  stream_byte
//  out      source     out_valid/out_ready kind, receiver_index, payload_byte,
//                                          byte_index, packet_length, last
//  apb      slave      psel/penable/pready paddr, pwdata, prdata
//
// One byte is taken every cycle while the result queue has room; a result reaches the queue at the same edge.
// A result leaves the queue in the cycle after its transfer in at the earliest.
// The front end stalls only when the result queue (QUEUE_DEPTH entries) is full.
// Reset is asynchronous, active low, and clears the queue and hunting state.
`default_nettype none

module magic_length_packet_deframer #(
    parameter int unsigned QUEUE_DEPTH = mld_pkg::QueueDepth
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mld_pkg::AddrWidth-1:0]       paddr,
    input  wire logic [mld_pkg::DataWidth-1:0]       pwdata,
    output logic      [mld_pkg::DataWidth-1:0]       prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          stream_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [mld_pkg::KindWidth-1:0]       kind,
    output logic      [mld_pkg::IndexWidth-1:0]      receiver_index,
    output logic      [7:0]                          payload_byte,
    output logic      [mld_pkg::CountWidth-1:0]      byte_index,
    output logic      [mld_pkg::LengthWidth-1:0]     packet_length,
    output logic                                     last
);
    import mld_pkg::*;

    mld_cfg_t    cfg;
    mld_result_t push_data;
    mld_result_t pop_data;
    logic        push_valid;
    logic        queue_ready;

    mld_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .queue_ready (queue_ready),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    mld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (queue_ready),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (pop_data)
    );

    assign kind           = pop_data.kind;
    assign receiver_index = pop_data.receiver_index;
    assign payload_byte   = pop_data.payload_byte;
    assign byte_index     = pop_data.byte_index;
    assign packet_length  = pop_data.packet_length;
    assign last           = pop_data.last;

endmodule

`default_nettype wire

// ----- bench/tb_magic_length_packet_deframer.sv -----
`timescale 1ns / 100ps
// Testbench of the magic/length packet deframer: byte stream stimulus checked against a predictor.
module tb_magic_length_packet_deframer;

    import mld_pkg::*;

    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned PhaseBytes   = 225;
    localparam int unsigned SettleCycles = 10;
    localparam int unsigned PhaseCount   = 6;

    typedef enum logic [1:0] {
        PH_HUNTING,
        PH_HEADER,
        PH_PAYLOAD
    } deframe_phase_t;

    typedef struct {
        logic [7:0] data;
        bit         hold_for_drain;
    } link_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [AddrWidth-1:0]   paddr = '0;
    logic [DataWidth-1:0]   pwdata = '0;
    logic [DataWidth-1:0]   prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             stream_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [KindWidth-1:0]   kind;
    logic [IndexWidth-1:0]  receiver_index;
    logic [7:0]             payload_byte;
    logic [CountWidth-1:0]  byte_index;
    logic [LengthWidth-1:0] packet_length;
    logic                   last;

    magic_length_packet_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .receiver_index (receiver_index),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .packet_length  (packet_length),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mld_cfg_t cfg = '{
        magic_word:  MagicReset,
        name_zero:   NameZeroReset,
        name_one:    NameOneReset,
        name_two:    NameTwoReset,
        name_three:  NameThreeReset,
        max_payload: MaxPayloadReset
    };

    deframe_phase_t        rx_phase = PH_HUNTING;
    logic [31:0]           hunt_window = '0;
    logic [2:0]            header_taken = '0;
    logic [31:0]           name_shift = '0;
    logic [15:0]           length_field = '0;
    logic [CountWidth-1:0] payload_taken = '0;
    logic [IndexWidth-1:0] receiver_match = RECEIVER_UNKNOWN;

    mld_result_t deframed_results[$];
    mld_result_t oldest_result;
    link_byte_t  link_bytes[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned frames_planned = 0;
    logic        in_taken = 1'b0;

    task automatic restart_hunt();
        rx_phase = PH_HUNTING;
        hunt_window = '0;
        header_taken = '0;
    endtask

    task automatic push_deframed(input logic [KindWidth-1:0] k, input logic [7:0] data,
                                 input logic [CountWidth-1:0] idx, input logic fin);
        mld_result_t r;
        r.kind = k;
        r.receiver_index = receiver_match;
        r.payload_byte = data;
        r.byte_index = idx;
        r.packet_length = length_field;
        r.last = fin;
        deframed_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic fin;
        case (rx_phase)
            PH_HEADER:
            begin
                if (header_taken < 3'd4)
                begin
                    name_shift = {name_shift[23:0], b};
                    header_taken = header_taken + 3'd1;
                end
                else if (header_taken == 3'd4)
                begin
                    length_field = {8'h00, b};
                    header_taken = 3'd5;
                end
                else
                begin
                    length_field = {b, length_field[7:0]};
                    if (name_shift == cfg.name_zero)
                        receiver_match = 3'd0;
                    else if (name_shift == cfg.name_one)
                        receiver_match = 3'd1;
                    else if (name_shift == cfg.name_two)
                        receiver_match = 3'd2;
                    else if (name_shift == cfg.name_three)
                        receiver_match = 3'd3;
                    else
                        receiver_match = RECEIVER_UNKNOWN;
                    payload_taken = '0;
                    if (length_field == 16'd0)
                    begin
                        push_deframed(KIND_EMPTY, 8'h00, '0, 1'b1);
                        restart_hunt();
                    end
                    else if (length_field > {1'b0, cfg.max_payload})
                    begin
                        push_deframed(KIND_DROP, 8'h00, '0, 1'b1);
                        restart_hunt();
                    end
                    else
                    begin
                        rx_phase = PH_PAYLOAD;
                        header_taken = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                fin = ({1'b0, payload_taken} + 16'd1) >= length_field;
                push_deframed(KIND_PAYLOAD, b, payload_taken, fin);
                payload_taken = payload_taken + 1'b1;
                if (fin)
                    restart_hunt();
            end
            default:
            begin
                rx_phase = PH_HUNTING;
                hunt_window = {hunt_window[23:0], b};
                if (header_taken < 3'd4)
                    header_taken = header_taken + 3'd1;
                if (header_taken >= 3'd4 && hunt_window == cfg.magic_word)
                begin
                    rx_phase = PH_HEADER;
                    header_taken = '0;
                    hunt_window = '0;
                    name_shift = '0;
                    length_field = '0;
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_MAGIC_WORD:  cfg.magic_word = pwdata;
                REG_NAME_ZERO:   cfg.name_zero = pwdata;
                REG_NAME_ONE:    cfg.name_one = pwdata;
                REG_NAME_TWO:    cfg.name_two = pwdata;
                REG_NAME_THREE:  cfg.name_three = pwdata;
                REG_MAX_PAYLOAD: cfg.max_payload = pwdata[CountWidth-1:0];
                default: ;
            endcase
        end
        if (in_valid && in_ready)
            deframe_byte(stream_byte);
        if (out_valid && out_ready)
        begin
            if (deframed_results.size() == 0)
            begin
                $display("%0t: result with none expected: kind %0d, byte %0d, index %0d",
                         $time, kind, payload_byte, byte_index);
                mismatches++;
            end
            else
            begin
                oldest_result = deframed_results.pop_front();
                check_field("kind", oldest_result.kind, kind);
                check_field("receiver_index", oldest_result.receiver_index, receiver_index);
                check_field("payload_byte", oldest_result.payload_byte, payload_byte);
                check_field("byte_index", oldest_result.byte_index, byte_index);
                check_field("packet_length", oldest_result.packet_length, packet_length);
                check_field("last", oldest_result.last, last);
            end
        end
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        logic       next_valid;
        logic [7:0] next_byte;
        link_byte_t item;
        next_valid = in_valid;
        next_byte = stream_byte;
        if (!in_valid || in_taken)
        begin
            next_valid = 1'b0;
            if (rst_n && link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(link_bytes[0].hold_for_drain && deframed_results.size() != 0))
            begin
                item = link_bytes.pop_front();
                next_valid = 1'b1;
                next_byte = item.data;
            end
        end
        in_valid <= next_valid;
        stream_byte <= next_byte;
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] data, input bit hold);
        link_byte_t item;
        item.data = data;
        item.hold_for_drain = hold;
        link_bytes.push_back(item);
    endtask

    task automatic push_word(input logic [31:0] word, input bit hold);
        push_byte(word[31:24], hold);
        push_byte(word[23:16], 1'b0);
        push_byte(word[15:8], 1'b0);
        push_byte(word[7:0], 1'b0);
    endtask

    task automatic add_frame(input logic [31:0] nm, input logic [15:0] len, input bit hold);
        push_word(cfg.magic_word, hold);
        push_word(nm, 1'b0);
        push_byte(len[7:0], 1'b0);
        push_byte(len[15:8], 1'b0);
        if (len <= {1'b0, cfg.max_payload})
            repeat (len) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic add_traffic();
        int unsigned pick;
        int unsigned n;
        logic [31:0] nm;
        logic [15:0] len;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom), 1'b0);
        end
        else if (pick < 20)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(cfg.magic_word[31 - 8*i -: 8], 1'b0);
            push_byte(8'($urandom), 1'b0);
        end
        else if (pick < 25)
        begin
            push_word(cfg.magic_word, 1'b0);
            n = $urandom_range(1, 5);
            repeat (n) push_byte(8'($urandom), 1'b0);
        end
        else
        begin
            case ($urandom_range(5))
                0: nm = cfg.name_zero;
                1: nm = cfg.name_one;
                2: nm = cfg.name_two;
                3: nm = cfg.name_three;
                4: nm = $urandom;
                default: nm = cfg.name_one ^ (32'd1 << $urandom_range(31));
            endcase
            case ($urandom_range(9))
                0: len = '0;
                1, 2, 3, 4: len = 16'($urandom_range(1, 12));
                5: len = {1'b0, cfg.max_payload};
                6: len = {1'b0, cfg.max_payload} + 16'd1;
                7: len = 16'($urandom_range(16'h8000, 16'hFFFF));
                8: len = 16'($urandom);
                default: len = 16'($urandom_range(13, 40));
            endcase
            if (len != 16'd0 && len <= {1'b0, cfg.max_payload} && len > 16'd64)
                len = 16'($urandom_range(1, 64));
            frames_planned++;
            add_frame(nm, len, frames_planned % 8 == 0);
        end
    endtask

    initial
    begin
        logic [31:0]           magic;
        logic [31:0]           names[4];
        logic [CountWidth-1:0] max_len;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (p == 0)
            begin
                push_byte(8'hFF, 1'b0);
                add_frame(cfg.name_zero, 16'h0000, 1'b0);
                add_frame(32'h0000_0000, 16'hFFFF, 1'b0);
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    names[i] = $urandom;
                magic = $urandom;
                case (p)
                    1: max_len = 15'd40;
                    2:
                    begin
                        magic = 32'h0000_0000;
                        names[1] = names[0];
                        names[2] = 32'h0000_0000;
                        names[3] = 32'hFFFF_FFFF;
                        max_len = 15'd0;
                    end
                    3:
                    begin
                        magic = 32'hFFFF_FFFF;
                        max_len = 15'h7FFF;
                    end
                    4:
                    begin
                        names[3] = names[0];
                        max_len = 15'd1;
                    end
                    default:
                    begin
                        magic = MagicReset;
                        names[0] = NameZeroReset;
                        names[1] = NameOneReset;
                        names[2] = NameTwoReset;
                        names[3] = NameThreeReset;
                        max_len = MaxPayloadReset;
                    end
                endcase
                write_reg(REG_MAGIC_WORD, magic);
                write_reg(REG_NAME_ZERO, names[0]);
                write_reg(REG_NAME_ONE, names[1]);
                write_reg(REG_NAME_TWO, names[2]);
                write_reg(REG_NAME_THREE, names[3]);
                write_reg(REG_MAX_PAYLOAD, {17'd0, max_len});
            end
            while (link_bytes.size() < PhaseBytes)
                add_traffic();
            while (link_bytes.size() != 0 || in_valid || deframed_results.size() != 0)
                @(posedge clk);
            repeat (SettleCycles) @(posedge clk);
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mld_pkg.sv
hw/rtl/mld_cfg.sv
hw/rtl/mld_front.sv
hw/rtl/mld_queue.sv
hw/rtl/magic_length_packet_deframer.sv
bench/tb_magic_length_packet_deframer.sv
